// ===== design/qte_pkg.sv =====
// Shared widths, constants, types and helper functions for the quaternion to
// Euler angle core. No dependencies; every design file refers to it by scope.
package qte_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int COMP_BITS   = 16;
    localparam int ALIGN_BITS  = 16;                 // components aligned to Q1.14
    localparam int FRAC_SHIFT  = 28;                 // 1.0 = 2^28 after products
    localparam int PROD_W      = 2 * ALIGN_BITS;
    localparam int SUM_W       = PROD_W + 2;
    localparam int CORD_W      = SUM_W + 3;          // room for CORDIC gain and rotation
    localparam int ROOT_W      = FRAC_SHIFT + 1;
    localparam int NSQ_W       = 2 * ROOT_W;
    localparam int ISQRT_STEPS = ROOT_W;
    localparam int ATAN_ITERS  = 30;
    localparam int CORDIC_LAT  = ATAN_ITERS + 1;

    localparam logic signed [SUM_W-1:0] FRAC_ONE = SUM_W'(1) << FRAC_SHIFT;
    localparam logic [NSQ_W-1:0] NSQ_ONE = NSQ_W'(1) << (2 * FRAC_SHIFT);

    localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

    localparam logic signed [ANGLE_BITS-1:0] PITCH_LIMIT = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // atan(2^-i), 2^32 per turn
    localparam logic [31:0] ATAN_TAB [ATAN_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] sinr;
        logic signed [SUM_W-1:0] cosr;
        logic signed [SUM_W-1:0] siny;
        logic signed [SUM_W-1:0] cosy;
        logic signed [SUM_W-1:0] sinp;
        logic                    clamped;
        logic                    clamp_pos;
    } side_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll;
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] yaw;
        logic                         clamped;
    } result_t;

    // Round a 32-bit binary angle half up to ANGLE_BITS, wrapping mod a turn.
    function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [31:0] z);
        logic [33:0] s;
        s = {1'b0, z, 1'b0} + (34'd1 << (32 - ANGLE_BITS));
        return s[33-ANGLE_BITS +: ANGLE_BITS];
    endfunction

    // Align a component to Q1.14: floor shift right when wider, shift left when narrower.
    function automatic logic signed [ALIGN_BITS-1:0] align_comp(
        input logic signed [COMP_BITS-1:0] c
    );
        logic signed [ALIGN_BITS-1:0] t;
        if (COMP_BITS >= ALIGN_BITS)
        begin
            t = ALIGN_BITS'(c >>> (COMP_BITS - ALIGN_BITS));
        end
        else
        begin
            t = ALIGN_BITS'(c) <<< (ALIGN_BITS - COMP_BITS);
        end
        return t;
    endfunction

endpackage

// ===== design/qte_front.sv =====
// Front end: component products, trig sums, pitch clamp test, sinp squared and
// the square root operand. Four register stages. Depends on qte_pkg.
module qte_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    v_in,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_w,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_x,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_y,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_z,
    output logic                                    v_out,
    output logic [qte_pkg::NSQ_W-1:0]               n_out,
    output qte_pkg::side_t                          side_out
);

    logic signed [qte_pkg::ALIGN_BITS-1:0] a_w, a_x, a_y, a_z;
    logic signed [qte_pkg::PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [qte_pkg::PROD_W-1:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    qte_pkg::side_t side2_next, side2_reg, side3_reg, side4_reg;
    logic signed [qte_pkg::ROOT_W-1:0] sp;
    logic signed [qte_pkg::NSQ_W-1:0]  sq_next;
    logic [qte_pkg::NSQ_W-1:0]         sq_reg, n_reg;
    logic [3:0]                        v_reg;

    assign a_w = qte_pkg::align_comp(comp_w);
    assign a_x = qte_pkg::align_comp(comp_x);
    assign a_y = qte_pkg::align_comp(comp_y);
    assign a_z = qte_pkg::align_comp(comp_z);

    always_comb
    begin
        side2_next.sinr = (qte_pkg::SUM_W'(p_wx_reg) + qte_pkg::SUM_W'(p_yz_reg)) <<< 1;
        side2_next.cosr = qte_pkg::FRAC_ONE
                          - ((qte_pkg::SUM_W'(p_xx_reg) + qte_pkg::SUM_W'(p_yy_reg)) <<< 1);
        side2_next.sinp = (qte_pkg::SUM_W'(p_wy_reg) - qte_pkg::SUM_W'(p_zx_reg)) <<< 1;
        side2_next.siny = (qte_pkg::SUM_W'(p_wz_reg) + qte_pkg::SUM_W'(p_xy_reg)) <<< 1;
        side2_next.cosy = qte_pkg::FRAC_ONE
                          - ((qte_pkg::SUM_W'(p_yy_reg) + qte_pkg::SUM_W'(p_zz_reg)) <<< 1);
        side2_next.clamp_pos = (side2_next.sinp >= qte_pkg::FRAC_ONE);
        side2_next.clamped   = side2_next.clamp_pos || (side2_next.sinp <= -qte_pkg::FRAC_ONE);
    end

    // Only meaningful when pitch is not clamped, where |sinp| < 2^28.
    assign sp      = side2_reg.sinp[qte_pkg::ROOT_W-1:0];
    assign sq_next = sp * sp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg  <= qte_pkg::PROD_W'(a_w) * qte_pkg::PROD_W'(a_x);
            p_yz_reg  <= qte_pkg::PROD_W'(a_y) * qte_pkg::PROD_W'(a_z);
            p_xx_reg  <= qte_pkg::PROD_W'(a_x) * qte_pkg::PROD_W'(a_x);
            p_yy_reg  <= qte_pkg::PROD_W'(a_y) * qte_pkg::PROD_W'(a_y);
            p_wy_reg  <= qte_pkg::PROD_W'(a_w) * qte_pkg::PROD_W'(a_y);
            p_zx_reg  <= qte_pkg::PROD_W'(a_z) * qte_pkg::PROD_W'(a_x);
            p_wz_reg  <= qte_pkg::PROD_W'(a_w) * qte_pkg::PROD_W'(a_z);
            p_xy_reg  <= qte_pkg::PROD_W'(a_x) * qte_pkg::PROD_W'(a_y);
            p_zz_reg  <= qte_pkg::PROD_W'(a_z) * qte_pkg::PROD_W'(a_z);
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            sq_reg    <= sq_next;
            side4_reg <= side3_reg;
            n_reg     <= qte_pkg::NSQ_ONE - sq_reg;
        end
    end

    assign v_out    = v_reg[3];
    assign n_out    = n_reg;
    assign side_out = side4_reg;

endmodule

// ===== design/qte_isqrt.sv =====
// Pipelined floor integer square root, one result bit per stage, with the
// trig operands carried alongside. Depends on qte_pkg.
module qte_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           v_in,
    input  logic [qte_pkg::NSQ_W-1:0]      n_in,
    input  qte_pkg::side_t                 side_in,
    output logic                           v_out,
    output logic [qte_pkg::ROOT_W-1:0]     root_out,
    output qte_pkg::side_t                 side_out
);

    localparam int STEPS = qte_pkg::ISQRT_STEPS;

    logic [qte_pkg::NSQ_W-1:0] n_pipe [STEPS];
    logic [qte_pkg::NSQ_W-1:0] r_pipe [STEPS];
    qte_pkg::side_t            s_pipe [STEPS];
    logic [STEPS-1:0]          v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STEPS-2:0], v_in};
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam logic [qte_pkg::NSQ_W-1:0] BIT = qte_pkg::NSQ_W'(1) << (2 * (STEPS - 1 - j));
        logic [qte_pkg::NSQ_W-1:0] n_src, r_src, trial, n_next, r_next;
        qte_pkg::side_t            s_src;

        if (j == 0)
        begin : g_first
            assign n_src = n_in;
            assign r_src = '0;
            assign s_src = side_in;
        end
        else
        begin : g_rest
            assign n_src = n_pipe[j-1];
            assign r_src = r_pipe[j-1];
            assign s_src = s_pipe[j-1];
        end

        assign trial = r_src + BIT;

        always_comb
        begin
            if (n_src >= trial)
            begin
                n_next = n_src - trial;
                r_next = (r_src >> 1) + BIT;
            end
            else
            begin
                n_next = n_src;
                r_next = r_src >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_pipe[j] <= n_next;
                r_pipe[j] <= r_next;
                s_pipe[j] <= s_src;
            end
        end
    end

    assign v_out    = v_reg[STEPS-1];
    assign root_out = r_pipe[STEPS-1][qte_pkg::ROOT_W-1:0];
    assign side_out = s_pipe[STEPS-1];

endmodule

// ===== design/qte_cordic.sv =====
// Pipelined CORDIC atan2 in vectoring mode: quarter turn pre-rotation, one
// micro-rotation per stage, then rounding to a binary angle. Depends on qte_pkg.
module qte_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 v_in,
    input  logic signed [qte_pkg::SUM_W-1:0]     y_in,
    input  logic signed [qte_pkg::SUM_W-1:0]     x_in,
    output logic                                 v_out,
    output logic [qte_pkg::ANGLE_BITS-1:0]       angle_out
);

    localparam int ITERS = qte_pkg::ATAN_ITERS;

    logic signed [qte_pkg::CORD_W-1:0] xe, ye, xp_next, yp_next, xp_reg, yp_reg;
    logic [31:0]                       zp_next, zp_reg;
    logic                              zf_reg;
    logic [ITERS:0]                    v_reg;
    logic [ITERS-1:0]                  zf_pipe;
    logic signed [qte_pkg::CORD_W-1:0] x_pipe [ITERS];
    logic signed [qte_pkg::CORD_W-1:0] y_pipe [ITERS];
    logic [31:0]                       z_pipe [ITERS];

    assign xe = qte_pkg::CORD_W'(x_in);
    assign ye = qte_pkg::CORD_W'(y_in);

    // Fold the left half plane into the right one by a quarter turn.
    always_comb
    begin
        if (xe < 0)
        begin
            if (ye >= 0)
            begin
                xp_next = ye;
                yp_next = -xe;
                zp_next = qte_pkg::QUARTER_TURN;
            end
            else
            begin
                xp_next = -ye;
                yp_next = xe;
                zp_next = qte_pkg::THREE_QUARTER_TURN;
            end
        end
        else
        begin
            xp_next = xe;
            yp_next = ye;
            zp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ITERS-1:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg <= xp_next;
            yp_reg <= yp_next;
            zp_reg <= zp_next;
            zf_reg <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        logic signed [qte_pkg::CORD_W-1:0] x_src, y_src, xs, ys;
        logic [31:0]                       z_src;
        logic                              zf_src;

        if (i == 0)
        begin : g_first
            assign x_src  = xp_reg;
            assign y_src  = yp_reg;
            assign z_src  = zp_reg;
            assign zf_src = zf_reg;
        end
        else
        begin : g_rest
            assign x_src  = x_pipe[i-1];
            assign y_src  = y_pipe[i-1];
            assign z_src  = z_pipe[i-1];
            assign zf_src = zf_pipe[i-1];
        end

        assign xs = x_src >>> i;
        assign ys = y_src >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zf_pipe[i] <= zf_src;
                if (y_src > 0)
                begin
                    x_pipe[i] <= x_src + ys;
                    y_pipe[i] <= y_src - xs;
                    z_pipe[i] <= z_src + qte_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_pipe[i] <= x_src - ys;
                    y_pipe[i] <= y_src + xs;
                    z_pipe[i] <= z_src - qte_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    assign v_out     = v_reg[ITERS];
    assign angle_out = zf_pipe[ITERS-1] ? '0 : qte_pkg::round_angle(z_pipe[ITERS-1]);

endmodule

// ===== design/qte_outbuf.sv =====
// Output register with a one-entry skid stage; its ready is registered and
// freezes the pipeline. Depends on qte_pkg.
module qte_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               v_in,
    input  qte_pkg::result_t   data_in,
    output logic               ready,
    output logic               v_out,
    output qte_pkg::result_t   data_out,
    input  logic               stall
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    qte_pkg::result_t out_data_reg, out_data_next;
    qte_pkg::result_t skid_data_reg, skid_data_next;
    logic             push, out_free;

    assign ready    = !skid_valid_reg;
    assign push     = v_in && !skid_valid_reg;
    assign out_free = !out_valid_reg || !stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (out_free && skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (out_free)
        begin
            out_valid_next = push;
            out_data_next  = data_in;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = data_in;
        end
        else
        begin
            // Hold both registers.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign v_out    = out_valid_reg;
    assign data_out = out_data_reg;

endmodule

// ===== design/quaternion_to_euler_angles_core.sv =====
// Quaternion to Euler roll/pitch/yaw. An input transfer passes the front end, the
// square root, the CORDIC units and the output register before its result is valid.
// Throughput: one transfer per cycle; the whole pipeline advances together and
// holds only while its output skid stage is full. Reset (rst_n, async, low)
// clears every valid bit; data registers are not reset. Depends on qte_pkg,
// qte_front, qte_isqrt, qte_cordic and qte_outbuf.
module quaternion_to_euler_angles_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_w,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_x,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_y,
    input  logic signed [qte_pkg::COMP_BITS-1:0]    comp_z,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [qte_pkg::ANGLE_BITS-1:0]   roll_angle,
    output logic signed [qte_pkg::ANGLE_BITS-1:0]   pitch_angle,
    output logic signed [qte_pkg::ANGLE_BITS-1:0]   yaw_angle,
    output logic                                    pitch_clamped
);

    localparam int LAT = qte_pkg::CORDIC_LAT;

    logic                              en;
    logic                              ready_w;
    logic                              front_v, root_v, pipe_v;
    logic [qte_pkg::NSQ_W-1:0]         front_n;
    qte_pkg::side_t                    front_side, root_side;
    logic [qte_pkg::ROOT_W-1:0]        root;
    logic signed [qte_pkg::SUM_W-1:0]  root_ext;
    logic [qte_pkg::ANGLE_BITS-1:0]    roll_raw, pitch_raw, yaw_raw;
    logic [LAT-1:0]                    clamp_pipe, pos_pipe;
    qte_pkg::result_t                  res_in, res_out;

    // Every stage advances only while the skid stage has room.
    assign en         = ready_w;
    assign item_stall = !ready_w;

    // Products, trig sums, clamp test and 2^56 - sinp^2.
    qte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (item_valid),
        .comp_w   (comp_w),
        .comp_x   (comp_x),
        .comp_y   (comp_y),
        .comp_z   (comp_z),
        .v_out    (front_v),
        .n_out    (front_n),
        .side_out (front_side)
    );

    // cos(pitch) as sqrt(1 - sinp^2); roll and yaw operands ride along.
    qte_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (front_v),
        .n_in     (front_n),
        .side_in  (front_side),
        .v_out    (root_v),
        .root_out (root),
        .side_out (root_side)
    );

    assign root_ext = qte_pkg::SUM_W'(root);

    // Three angle units in lockstep; pitch's valid stands for all of them.
    qte_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .v_in      (root_v),
        .y_in      (root_side.sinr),
        .x_in      (root_side.cosr),
        .v_out     (),
        .angle_out (roll_raw)
    );

    qte_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .v_in      (root_v),
        .y_in      (root_side.sinp),
        .x_in      (root_ext),
        .v_out     (pipe_v),
        .angle_out (pitch_raw)
    );

    qte_cordic u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .v_in      (root_v),
        .y_in      (root_side.siny),
        .x_in      (root_side.cosy),
        .v_out     (),
        .angle_out (yaw_raw)
    );

    // Carry the clamp decision past the CORDIC stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_pipe <= {clamp_pipe[LAT-2:0], root_side.clamped};
            pos_pipe   <= {pos_pipe[LAT-2:0], root_side.clamp_pos};
        end
    end

    // Override pitch with a signed quarter turn when |sinp| reached one.
    always_comb
    begin
        res_in.roll    = roll_raw;
        res_in.yaw     = yaw_raw;
        res_in.clamped = clamp_pipe[LAT-1];
        if (clamp_pipe[LAT-1])
        begin
            res_in.pitch = pos_pipe[LAT-1] ? qte_pkg::PITCH_LIMIT : -qte_pkg::PITCH_LIMIT;
        end
        else
        begin
            res_in.pitch = pitch_raw;
        end
    end

    qte_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .v_in     (pipe_v),
        .data_in  (res_in),
        .ready    (ready_w),
        .v_out    (result_valid),
        .data_out (res_out),
        .stall    (result_stall)
    );

    assign roll_angle    = res_out.roll;
    assign pitch_angle   = res_out.pitch;
    assign yaw_angle     = res_out.yaw;
    assign pitch_clamped = res_out.clamped;

endmodule

// ===== design/qte_checker.sv =====
// Port-level checks for the quaternion to Euler angle core, bound to its top
// level. Depends on qte_pkg and quaternion_to_euler_angles_core.
module qte_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    input  logic                                    item_stall,
    input  logic                                    result_valid,
    input  logic                                    result_stall,
    input  logic signed [qte_pkg::ANGLE_BITS-1:0]   roll_angle,
    input  logic signed [qte_pkg::ANGLE_BITS-1:0]   pitch_angle,
    input  logic signed [qte_pkg::ANGLE_BITS-1:0]   yaw_angle,
    input  logic                                    pitch_clamped
);

    // Hold a stalled result.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(roll_angle)
        && $stable(pitch_angle) && $stable(yaw_angle) && $stable(pitch_clamped))
        else $error("stalled result changed");

    // A clamped pitch is exactly a signed quarter turn.
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && pitch_clamped |->
        pitch_angle == qte_pkg::PITCH_LIMIT || pitch_angle == -qte_pkg::PITCH_LIMIT)
        else $error("clamped pitch is not a quarter turn");

    // Pitch never leaves the quarter turn range.
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        pitch_angle <= qte_pkg::PITCH_LIMIT && pitch_angle >= -qte_pkg::PITCH_LIMIT)
        else $error("pitch out of range");

    // The input side stalls only after a result was left waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> !item_stall)
        else $error("input stalled with no waiting result");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (.*);
